### rtl/core/cabc_pkg.sv
// Shared types and constants for the climate alarm band checker.
// Holds the item structs, register map, per-kind margins and holdoff time.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package cabc_pkg;

  localparam int NUM_KINDS    = 4;
  localparam int MARGIN_KINDS = 4;
  localparam int KIDX_W       = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

  localparam int VAL_W  = 24;
  localparam int DIFF_W = 26;
  localparam int TIME_W = 32;

  localparam int REG_COUNT = 8;
  localparam int RIDX_W    = 3;
  localparam int ADDR_W    = RIDX_W + 2;
  localparam int DATA_W    = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [TIME_W-1:0] HOLDOFF_MS = 32'd300000;

  localparam logic signed [VAL_W-1:0] TARGET_RESET [REG_COUNT] = '{
    24'sd2500, 24'sd2000, 24'sd6000, 24'sd6000,
    24'sd100, 24'sd80, 24'sd80000, 24'sd80000
  };

  typedef struct packed {
    logic [2:0]              sensor_kind;
    logic signed [VAL_W-1:0] reading;
    logic                    reading_valid;
    logic                    is_daytime;
    logic [TIME_W-1:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic alert_raised;
    logic is_critical;
    logic is_high;
  } out_item_t;

  // Classified reading handed from the front end to the back end.
  typedef struct packed {
    logic              kind_ok;
    logic [KIDX_W-1:0] kind_idx;
    logic              out_band;
    logic              critical;
    logic              high;
    logic [TIME_W-1:0] now_ms;
  } cls_item_t;

  function automatic logic signed [DIFF_W-1:0] margin_x2(input logic [1:0] kind);
    logic signed [DIFF_W-1:0] m;
    case (kind)
      2'd0:    m = 26'sd400;
      2'd1:    m = 26'sd2000;
      2'd2:    m = 26'sd40;
      default: m = 26'sd40000;
    endcase
    return m;
  endfunction

  function automatic logic signed [DIFF_W-1:0] margin_x3(input logic [1:0] kind);
    logic signed [DIFF_W-1:0] m;
    case (kind)
      2'd0:    m = 26'sd600;
      2'd1:    m = 26'sd3000;
      2'd2:    m = 26'sd60;
      default: m = 26'sd60000;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/cabc_queue.sv
// Two-entry queue of classified readings between front and back ends.
// Depends on cabc_pkg for the entry type and depth.
module cabc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  cabc_pkg::cls_item_t  wr_data,
  output logic                 full,
  input  logic                 rd,
  output cabc_pkg::cls_item_t  rd_data,
  output logic                 empty
);

  cabc_pkg::cls_item_t          slots [cabc_pkg::QUEUE_DEPTH];
  logic [cabc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [cabc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [cabc_pkg::QPTR_W:0]    count;
  logic                         do_wr;
  logic                         do_rd;

  assign full    = (count == (cabc_pkg::QPTR_W + 1)'(cabc_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/cabc_front.sv
// Front end: target registers behind the APB port and band classification.
// Depends on cabc_pkg for the register map, margins and item types.
module cabc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cabc_pkg::ADDR_W-1:0]         paddr,
  input  logic [cabc_pkg::DATA_W-1:0]         pwdata,
  output logic [cabc_pkg::DATA_W-1:0]         prdata,
  input  cabc_pkg::in_item_t                  item,
  output cabc_pkg::cls_item_t                 cls
);

  logic signed [cabc_pkg::VAL_W-1:0]  targets [cabc_pkg::REG_COUNT];
  logic [cabc_pkg::RIDX_W-1:0]        widx;
  logic [cabc_pkg::RIDX_W-1:0]        tidx;
  logic signed [cabc_pkg::VAL_W-1:0]  target;
  logic signed [cabc_pkg::DIFF_W-1:0] diff;
  logic signed [cabc_pkg::DIFF_W-1:0] m2;
  logic signed [cabc_pkg::DIFF_W-1:0] m3;
  logic                               kind_ok;

  assign widx = paddr[cabc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cabc_pkg::REG_COUNT; i++) begin
        targets[i] <= cabc_pkg::TARGET_RESET[i];
      end
    end else if (psel && penable && pwrite) begin
      targets[widx] <= pwdata[cabc_pkg::VAL_W-1:0];
    end
  end

  assign prdata = cabc_pkg::DATA_W'(targets[widx]);

  // Day targets sit at even indexes, night targets at the odd ones.
  assign tidx   = {item.sensor_kind[1:0], ~item.is_daytime};
  assign target = targets[tidx];
  assign diff   = cabc_pkg::DIFF_W'(item.reading) - cabc_pkg::DIFF_W'(target);
  assign m2     = cabc_pkg::margin_x2(item.sensor_kind[1:0]);
  assign m3     = cabc_pkg::margin_x3(item.sensor_kind[1:0]);

  assign kind_ok = item.reading_valid
                && ({1'b0, item.sensor_kind} < 4'(cabc_pkg::NUM_KINDS))
                && ({1'b0, item.sensor_kind} < 4'(cabc_pkg::MARGIN_KINDS));

  always_comb begin
    cls.kind_ok  = kind_ok;
    cls.kind_idx = item.sensor_kind[cabc_pkg::KIDX_W-1:0];
    cls.out_band = (diff < -m2) || (diff > m2);
    cls.critical = (diff < -m3) || (diff > m3);
    cls.high     = (diff > m2);
    cls.now_ms   = item.now_ms;
  end

endmodule

### rtl/core/cabc_back.sv
// Back end: per-kind holdoff state, alert decision and the result register.
// Depends on cabc_pkg for the holdoff time and item types.
module cabc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cabc_pkg::cls_item_t  cls,
  input  logic                 cls_empty,
  output logic                 cls_pop,
  output cabc_pkg::out_item_t  result,
  output logic                 empty,
  input  logic                 pop
);

  logic [cabc_pkg::TIME_W-1:0] last_alert_time [cabc_pkg::NUM_KINDS];
  logic [cabc_pkg::NUM_KINDS-1:0] holdoff_armed;
  logic                           out_valid;
  logic [cabc_pkg::TIME_W-1:0]    elapsed;
  logic                           held;
  logic                           fire;
  logic                           take;

  assign take    = !cls_empty && (!out_valid || pop);
  assign cls_pop = take;
  assign empty   = !out_valid;

  // Elapsed time wraps modulo 2^32, so a plain subtraction is enough.
  assign elapsed = cls.now_ms - last_alert_time[cls.kind_idx];
  assign held    = holdoff_armed[cls.kind_idx] && (elapsed < cabc_pkg::HOLDOFF_MS);
  assign fire    = cls.kind_ok && cls.out_band && !held;

  always_ff @(posedge clk) begin
    if (take && fire) begin
      last_alert_time[cls.kind_idx] <= cls.now_ms;
    end
    if (take) begin
      result.alert_raised <= fire;
      result.is_critical  <= fire && cls.critical;
      result.is_high      <= fire && cls.high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_armed <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take && fire) begin
        holdoff_armed[cls.kind_idx] <= 1'b1;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/climate_alarm_band_checker_unit.sv
// Climate alarm band checker: day/night target bands with per-kind alert holdoff.
// Readings enter through a push/full queue port; one result per reading leaves
// through an empty/pop queue port. Eight 24-bit targets sit behind an APB port.
// Usage:
//   Push one reading per transaction; each yields exactly one result, in order.
//   The front end classifies a reading against its band in the cycle it is
//   pushed and writes it into a two-entry queue. The back end applies the
//   per-kind holdoff and loads the result register.
//   A reading passes from the queue into the result register, where it can
//   be popped; while the result register is held, the reading waits in the queue.
//   Throughput: one reading per cycle while results are popped, set by the
//   holdoff update in the back end, which lets consecutive same-kind readings follow.
//   If the receiver stops popping, the result register and the queue fill,
//   then full rises; nothing is dropped. Popping resumes the flow at once.
//   Reset (synchronous, rst high) loads the default targets, disarms every
//   holdoff and empties the queue and result register.
//   The user must write targets only while no reading is in flight; the block
//   does not enforce this. prdata returns the sign-extended target at paddr.
module climate_alarm_band_checker_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  cabc_pkg::in_item_t           item,
  output logic                         empty,
  input  logic                         pop,
  output cabc_pkg::out_item_t          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cabc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cabc_pkg::DATA_W-1:0]  pwdata,
  output logic [cabc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  cabc_pkg::cls_item_t cls_in;
  cabc_pkg::cls_item_t cls_out;
  logic                cls_empty;
  logic                cls_pop;

  assign pready = 1'b1;

  cabc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .item    (item),
    .cls     (cls_in)
  );

  cabc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (cls_in),
    .full    (full),
    .rd      (cls_pop),
    .rd_data (cls_out),
    .empty   (cls_empty)
  );

  cabc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (cls_out),
    .cls_empty (cls_empty),
    .cls_pop   (cls_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
